FILE: rtl/core/conv3x3_zero_pad_saturate_u8_macros.svh
// Assertion macros used by the checker of the convolution block.
`ifndef CONV3X3_ZERO_PAD_SATURATE_U8_MACROS_SVH
`define CONV3X3_ZERO_PAD_SATURATE_U8_MACROS_SVH

// A property that is checked only while the block is out of reset.
`define C3X3_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A property that is checked at every edge, reset included.
`define C3X3_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/c3x3_pkg.sv
package c3x3_pkg;

    // Line store depth and the widths that follow from it.
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);

    localparam int PIX_W        = 8;
    localparam int ROW_W        = 12;
    localparam int WIDTH_CFG_W  = 11;
    localparam int HEIGHT_CFG_W = 12;
    localparam int COEF_W       = 16;
    localparam int KROW_W       = 3 * COEF_W;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = KROW_W;
    localparam int FRAC_W       = 8;

    // A coefficient times a pixel fits 24 signed bits, nine of them 28.
    localparam int PROD_W = COEF_W + PIX_W;
    localparam int SUM_W  = PROD_W + 4;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROW_TOP = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROW_MID = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_ROW_BOT = 3'd4;

    localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET      = 11'd1024;
    localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET     = 12'd1024;
    localparam logic [KROW_W-1:0]       KERNEL_MID_RESET = 48'h0000_0100_0000;

    // Result kinds of one pixel, in the order they are delivered.
    localparam int NUM_KINDS    = 4;
    localparam int KIND_UP_LEFT = 0;   // (r-1, c-1)
    localparam int KIND_UP      = 1;   // (r-1, c) at the end of a row
    localparam int KIND_LEFT    = 2;   // (r, c-1) in the last row
    localparam int KIND_HERE    = 3;   // (r, c) for the last pixel of the frame

    typedef logic [NUM_KINDS-1:0] t_kinds;

    // Window taps: first index is the row, second the column.
    typedef logic [2:0][2:0][PIX_W-1:0] t_window;

    // Coefficients: [kernel row][kernel column].
    typedef logic [2:0][2:0][COEF_W-1:0] t_kernel;

    typedef struct packed {
        logic [COL_W-1:0] col_last;
        logic [ROW_W-1:0] row_last;
    } t_geom;

    typedef struct packed {
        t_window          window;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        t_kinds           kinds;
        logic             row_eq0;
        logic             row_eq1;
        logic             col_eq0;
        logic             col_eq1;
    } t_item;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
        logic             eof;
    } t_tag;

    typedef struct packed {
        t_window taps;   // [kernel row][kernel column], padding already zeroed
        t_tag    tag;
    } t_taps;

endpackage

FILE: rtl/core/c3x3_line_buf.sv
module c3x3_line_buf (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_restart,
    input  c3x3_pkg::t_geom               i_geom,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [c3x3_pkg::PIX_W-1:0]    i_pixel,
    output logic                          o_valid,
    input  logic                          i_ready,
    output c3x3_pkg::t_item               o_item
);

    localparam int PixW = c3x3_pkg::PIX_W;
    localparam int ColW = c3x3_pkg::COL_W;
    localparam int RowW = c3x3_pkg::ROW_W;

    // Each entry holds the pixel two rows up (high byte) and one row up.
    logic [2*PixW-1:0] r_line_mem [c3x3_pkg::MAX_WIDTH];

    logic [RowW-1:0]       r_row;
    logic [ColW-1:0]       r_col;
    logic                  r_a_valid;
    logic [PixW-1:0]       r_a_px;
    logic [RowW-1:0]       r_a_row;
    logic [ColW-1:0]       r_a_col;
    c3x3_pkg::t_kinds      r_a_kinds;
    logic [3:0]            r_a_edge;
    logic                  r_a_fwd;
    logic [2*PixW-1:0]     r_a_fwd_data;
    logic [2*PixW-1:0]     r_rd;
    c3x3_pkg::t_window     r_window;

    logic                  accept;
    logic                  a_adv;
    logic [2*PixW-1:0]     rd_eff;
    c3x3_pkg::t_window     n_window;
    c3x3_pkg::t_kinds      kinds;
    logic                  row_first;
    logic                  col_first;
    logic                  row_last;
    logic                  col_last;

    assign a_adv   = r_a_valid && i_ready;
    assign o_ready = !r_a_valid || a_adv;
    assign accept  = i_valid && o_ready;

    assign row_first = (r_row == '0);
    assign col_first = (r_col == '0);
    assign row_last  = (r_row == i_geom.row_last);
    assign col_last  = (r_col == i_geom.col_last);

    always_comb begin
        kinds = '0;
        kinds[c3x3_pkg::KIND_UP_LEFT] = !row_first && !col_first;
        kinds[c3x3_pkg::KIND_UP]      = !row_first && col_last;
        kinds[c3x3_pkg::KIND_LEFT]    = row_last && !col_first;
        kinds[c3x3_pkg::KIND_HERE]    = row_last && col_last;
    end

    // Raster position of the next pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= row_last ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_ready) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_px       <= i_pixel;
            r_a_row      <= r_row;
            r_a_col      <= r_col;
            r_a_kinds    <= kinds;
            r_a_edge     <= {row_first, (r_row == RowW'(1)), col_first, (r_col == ColW'(1))};
            // The entry being written at this edge is read stale, so take it directly.
            r_a_fwd      <= a_adv && (r_a_col == r_col);
            r_a_fwd_data <= {rd_eff[PixW-1:0], r_a_px};
        end
    end

    // Line memory: read on accept, written back when the pixel moves on.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= r_line_mem[r_col];
        end
        if (a_adv) begin
            r_line_mem[r_a_col] <= {rd_eff[PixW-1:0], r_a_px};
        end
    end

    assign rd_eff = r_a_fwd ? r_a_fwd_data : r_rd;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_window[i][0] = r_window[i][1];
            n_window[i][1] = r_window[i][2];
        end
        n_window[0][2] = rd_eff[2*PixW-1:PixW];
        n_window[1][2] = rd_eff[PixW-1:0];
        n_window[2][2] = r_a_px;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_window <= '0;
        end else if (a_adv) begin
            r_window <= n_window;
        end
    end

    assign o_valid        = r_a_valid;
    assign o_item.window  = n_window;
    assign o_item.row     = r_a_row;
    assign o_item.col     = r_a_col;
    assign o_item.kinds   = r_a_kinds;
    assign o_item.row_eq0 = r_a_edge[3];
    assign o_item.row_eq1 = r_a_edge[2];
    assign o_item.col_eq0 = r_a_edge[1];
    assign o_item.col_eq1 = r_a_edge[0];

endmodule

FILE: rtl/core/c3x3_seq.sv
module c3x3_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  c3x3_pkg::t_item   i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output c3x3_pkg::t_taps   o_taps
);

    localparam int RowW = c3x3_pkg::ROW_W;
    localparam int ColW = c3x3_pkg::COL_W;

    c3x3_pkg::t_item  r_item;
    c3x3_pkg::t_kinds r_kinds;

    c3x3_pkg::t_kinds pick;
    c3x3_pkg::t_kinds rest;
    logic             dy;
    logic             dx;
    logic             y_zero;
    logic             x_zero;
    logic             fire;
    logic [1:0]       ii;
    logic [1:0]       jj;

    // Results still owed for the held pixel are taken lowest kind first.
    assign pick = r_kinds & (~r_kinds + 1'b1);
    assign rest = r_kinds & ~pick;

    assign dy = pick[c3x3_pkg::KIND_UP_LEFT] | pick[c3x3_pkg::KIND_UP];
    assign dx = pick[c3x3_pkg::KIND_UP_LEFT] | pick[c3x3_pkg::KIND_LEFT];

    assign y_zero = dy ? r_item.row_eq1 : r_item.row_eq0;
    assign x_zero = dx ? r_item.col_eq1 : r_item.col_eq0;

    assign o_valid = |r_kinds;
    assign fire    = o_valid && i_ready;
    assign o_ready = !o_valid || (i_ready && (rest == '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kinds <= '0;
        end else if (i_valid && o_ready) begin
            r_kinds <= i_item.kinds;
        end else if (fire) begin
            r_kinds <= rest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    // Coefficient (a,b) meets the tap at window row 3-a-dy, column 3-b-dx;
    // row or column three and neighbours beyond the frame edge read as zero.
    always_comb begin
        ii = '0;
        jj = '0;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                ii = 2'd3 - 2'(a) - {1'b0, dy};
                jj = 2'd3 - 2'(b) - {1'b0, dx};
                if (ii == 2'd3 || jj == 2'd3 || (a == 2 && y_zero) || (b == 2 && x_zero)) begin
                    o_taps.taps[a][b] = '0;
                end else begin
                    o_taps.taps[a][b] = r_item.window[ii][jj];
                end
            end
        end
        o_taps.tag.row  = r_item.row - RowW'(dy);
        o_taps.tag.col  = r_item.col - ColW'(dx);
        o_taps.tag.last = (rest == '0);
        o_taps.tag.eof  = pick[c3x3_pkg::KIND_HERE];
    end

endmodule

FILE: rtl/core/c3x3_mac.sv
module c3x3_mac (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  c3x3_pkg::t_kernel             i_kernel,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  c3x3_pkg::t_taps               i_taps,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [c3x3_pkg::PIX_W-1:0]    o_pixel,
    output c3x3_pkg::t_tag                o_tag
);

    localparam int PixW   = c3x3_pkg::PIX_W;
    localparam int ProdW  = c3x3_pkg::PROD_W;
    localparam int SumW   = c3x3_pkg::SUM_W;
    localparam int FracW  = c3x3_pkg::FRAC_W;
    localparam int IntW   = SumW - FracW;
    localparam int FullW  = c3x3_pkg::COEF_W + PixW + 1;

    // Stage M: products, stage P: row sums, stage S: total, stage O: output.
    logic                    r_m_valid;
    logic                    r_p_valid;
    logic                    r_s_valid;
    logic                    r_o_valid;
    c3x3_pkg::t_tag          r_m_tag;
    c3x3_pkg::t_tag          r_p_tag;
    c3x3_pkg::t_tag          r_s_tag;
    c3x3_pkg::t_tag          r_o_tag;
    logic signed [ProdW-1:0] r_prod [3][3];
    logic signed [SumW-1:0]  r_part [3];
    logic signed [SumW-1:0]  r_sum;
    logic [PixW-1:0]         r_pixel;

    logic                    ready_m;
    logic                    ready_p;
    logic                    ready_s;
    logic                    ready_o;
    logic signed [FullW-1:0] prod [3][3];
    logic signed [SumW-1:0]  part [3];
    logic [IntW-1:0]         q;
    logic [FracW-1:0]        frac;
    logic                    round_up;
    logic [IntW:0]           q_rnd;
    logic [PixW-1:0]         pixel;

    assign ready_o = !r_o_valid || i_ready;
    assign ready_s = !r_s_valid || ready_o;
    assign ready_p = !r_p_valid || ready_s;
    assign ready_m = !r_m_valid || ready_p;
    assign o_ready = ready_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_p_valid <= 1'b0;
            r_s_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (ready_m) begin
                r_m_valid <= i_valid;
            end
            if (ready_p) begin
                r_p_valid <= r_m_valid;
            end
            if (ready_s) begin
                r_s_valid <= r_p_valid;
            end
            if (ready_o) begin
                r_o_valid <= r_s_valid;
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                prod[a][b] = $signed(i_kernel[a][b]) * $signed({1'b0, i_taps.taps[a][b]});
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            part[a] = SumW'(r_prod[a][0]) + SumW'(r_prod[a][1]) + SumW'(r_prod[a][2]);
        end
    end

    // Round half to even on the Q8 fraction, then clamp to the pixel range.
    assign q        = r_sum[SumW-1:FracW];
    assign frac     = r_sum[FracW-1:0];
    assign round_up = (frac > 8'd128) || (frac == 8'd128 && q[0]);
    assign q_rnd    = {1'b0, q} + (IntW+1)'(round_up);

    always_comb begin
        if (r_sum[SumW-1] || r_sum == '0) begin
            pixel = '0;
        end else if (q_rnd > (IntW+1)'(255)) begin
            pixel = '1;
        end else begin
            pixel = q_rnd[PixW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_m && i_valid) begin
            r_m_tag <= i_taps.tag;
            for (int a = 0; a < 3; a++) begin
                for (int b = 0; b < 3; b++) begin
                    r_prod[a][b] <= prod[a][b][ProdW-1:0];
                end
            end
        end
        if (ready_p && r_m_valid) begin
            r_p_tag <= r_m_tag;
            for (int a = 0; a < 3; a++) begin
                r_part[a] <= part[a];
            end
        end
        if (ready_s && r_p_valid) begin
            r_s_tag <= r_p_tag;
            r_sum   <= r_part[0] + r_part[1] + r_part[2];
        end
        if (ready_o && r_s_valid) begin
            r_o_tag <= r_s_tag;
            r_pixel <= pixel;
        end
    end

    assign o_valid = r_o_valid;
    assign o_pixel = r_pixel;
    assign o_tag   = r_o_tag;

endmodule

FILE: rtl/core/conv3x3_zero_pad_saturate_u8.sv
// 3x3 convolution of an 8-bit greyscale frame in raster order, with zero
// padding, round-half-to-even and saturation to 0..255. Each accepted pixel
// produces the filtered pixels it completes, tagged with row and column,
// last_of_item marking the final one and end_of_frame the bottom-right pixel.
// Inside a frame a pixel yields one result and the block takes one pixel per
// clock while the output is not stalled; the pixel that ends a row yields two,
// each pixel of the last row two and the final pixel of the frame four, and the
// sequencer then takes the next pixel only once all of them are handed on, since
// the single output port delivers one result per clock while the receiver is ready.
// Coefficients are signed Q8.8 and are written three to a row register;
// writing the image width or height restarts the frame at the top-left.
// Configuration writes belong in idle periods; the port is always ready.
module conv3x3_zero_pad_saturate_u8 (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Pixel input channel.
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [c3x3_pkg::PIX_W-1:0]         i_pixel_in,
    // Result channel.
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [c3x3_pkg::PIX_W-1:0]         o_pixel_out,
    output logic [c3x3_pkg::ROW_W-1:0]         o_out_row,
    output logic [c3x3_pkg::COL_W-1:0]         o_out_col,
    output logic                               o_last_of_item,
    output logic                               o_end_of_frame,
    // Configuration write channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [c3x3_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [c3x3_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int ColW  = c3x3_pkg::COL_W;
    localparam int RowW  = c3x3_pkg::ROW_W;
    localparam int WEffW = c3x3_pkg::COL_W + 1;

    logic [c3x3_pkg::WIDTH_CFG_W-1:0]  r_width;
    logic [c3x3_pkg::HEIGHT_CFG_W-1:0] r_height;
    c3x3_pkg::t_kernel                 r_kernel;

    logic              cfg_we;
    logic              restart;
    logic [WEffW-1:0]  w_eff;
    c3x3_pkg::t_geom   geom;

    logic              lb_valid;
    logic              lb_ready;
    c3x3_pkg::t_item   lb_item;
    logic              sq_valid;
    logic              sq_ready;
    c3x3_pkg::t_taps   sq_taps;
    c3x3_pkg::t_tag    out_tag;

    // The configuration port never stalls a transaction.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign restart     = cfg_we && (i_cfg_index == c3x3_pkg::CFG_IMAGE_WIDTH ||
                                    i_cfg_index == c3x3_pkg::CFG_IMAGE_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= c3x3_pkg::WIDTH_RESET;
            r_height    <= c3x3_pkg::HEIGHT_RESET;
            r_kernel[0] <= '0;
            r_kernel[1] <= c3x3_pkg::KERNEL_MID_RESET;
            r_kernel[2] <= '0;
        end else if (cfg_we) begin
            case (i_cfg_index)
                c3x3_pkg::CFG_IMAGE_WIDTH: begin
                    r_width <= i_cfg_data[c3x3_pkg::WIDTH_CFG_W-1:0];
                end
                c3x3_pkg::CFG_IMAGE_HEIGHT: begin
                    r_height <= i_cfg_data[c3x3_pkg::HEIGHT_CFG_W-1:0];
                end
                c3x3_pkg::CFG_KERNEL_ROW_TOP: begin
                    r_kernel[0] <= i_cfg_data[c3x3_pkg::KROW_W-1:0];
                end
                c3x3_pkg::CFG_KERNEL_ROW_MID: begin
                    r_kernel[1] <= i_cfg_data[c3x3_pkg::KROW_W-1:0];
                end
                c3x3_pkg::CFG_KERNEL_ROW_BOT: begin
                    r_kernel[2] <= i_cfg_data[c3x3_pkg::KROW_W-1:0];
                end
                default: begin
                    // Writes beyond the register list are ignored.
                end
            endcase
        end
    end

    // A width of zero behaves as one and anything beyond the line store
    // depth behaves as the full depth; a height of zero behaves as one.
    always_comb begin
        if (r_width == '0) begin
            w_eff = WEffW'(1);
        end else if (r_width > c3x3_pkg::MAX_WIDTH) begin
            w_eff = WEffW'(c3x3_pkg::MAX_WIDTH);
        end else begin
            w_eff = WEffW'(r_width);
        end
    end

    assign geom.col_last = ColW'(w_eff - 1'b1);
    assign geom.row_last = (r_height == '0) ? '0 : RowW'(r_height - 1'b1);

    // Line memory, raster position and the 3x3 window.
    c3x3_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (restart),
        .i_geom    (geom),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_pixel   (i_pixel_in),
        .o_valid   (lb_valid),
        .i_ready   (lb_ready),
        .o_item    (lb_item)
    );

    // Hands out the results of one pixel one per cycle while the MAC pipeline takes them, with padding zeroed.
    c3x3_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (lb_valid),
        .o_ready (lb_ready),
        .i_item  (lb_item),
        .o_valid (sq_valid),
        .i_ready (sq_ready),
        .o_taps  (sq_taps)
    );

    // Nine multipliers in parallel, adder tree, rounding and the output register.
    c3x3_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_kernel (r_kernel),
        .i_valid  (sq_valid),
        .o_ready  (sq_ready),
        .i_taps   (sq_taps),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_pixel  (o_pixel_out),
        .o_tag    (out_tag)
    );

    assign o_out_row      = out_tag.row;
    assign o_out_col      = out_tag.col;
    assign o_last_of_item = out_tag.last;
    assign o_end_of_frame = out_tag.eof;

endmodule

FILE: rtl/core/c3x3_checker.sv
`include "conv3x3_zero_pad_saturate_u8_macros.svh"

module c3x3_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [c3x3_pkg::PIX_W-1:0]    i_pixel_out,
    input logic [c3x3_pkg::ROW_W-1:0]    i_out_row,
    input logic [c3x3_pkg::COL_W-1:0]    i_out_col,
    input logic                          i_last_of_item,
    input logic                          i_end_of_frame
);

    // The output register is empty straight after reset.
    `C3X3_ASSERT_ALWAYS(a_empty_after_reset, i_clk, !i_rst_n |=> !i_out_valid, "result valid after reset")

    // The bottom-right pixel is always the final result of its transaction.
    `C3X3_ASSERT(a_eof_is_last, i_clk, i_rst_n, (i_out_valid && i_end_of_frame) |-> i_last_of_item, "end of frame without last of item")

    // A stalled result stays offered.
    `C3X3_ASSERT(a_hold_valid, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> i_out_valid, "result dropped while stalled")

    // A stalled result keeps its payload.
    `C3X3_ASSERT(a_hold_data, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> ($stable(i_pixel_out) && $stable(i_out_row) && $stable(i_out_col) && $stable(i_last_of_item) && $stable(i_end_of_frame)), "result changed while stalled")

endmodule

bind conv3x3_zero_pad_saturate_u8 c3x3_checker u_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .i_pixel_out    (o_pixel_out),
    .i_out_row      (o_out_row),
    .i_out_col      (o_out_col),
    .i_last_of_item (o_last_of_item),
    .i_end_of_frame (o_end_of_frame)
);

FILE: sim/conv3x3_result_checker.sv
module conv3x3_result_checker
    import c3x3_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [PIX_W-1:0]      i_pixel_in,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [PIX_W-1:0]      i_pixel_out,
    input  logic [ROW_W-1:0]      i_out_row,
    input  logic [COL_W-1:0]      i_out_col,
    input  logic                  i_last_of_item,
    input  logic                  i_end_of_frame,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_outstanding,
    output int                    o_compared
);

    typedef struct {
        logic [PIX_W-1:0] pixel;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
        logic             eof;
    } filtered_t;

    filtered_t               awaited_pixels[$];
    logic [WIDTH_CFG_W-1:0]  frame_width;
    logic [HEIGHT_CFG_W-1:0] frame_height;
    logic [KROW_W-1:0]       kernel [3];
    logic [PIX_W-1:0]        older_row [MAX_WIDTH];
    logic [PIX_W-1:0]        newer_row [MAX_WIDTH];
    logic [PIX_W-1:0]        taps [3][3];
    int                      row_at;
    int                      col_at;
    int                      mismatches = 0;
    int                      compared = 0;

    function automatic int coefficient(input int kr, input int kc);
        logic signed [COEF_W-1:0] raw;
        raw = kernel[kr][COEF_W*kc +: COEF_W];
        return int'(raw);
    endfunction

    // Pixel (ar, ac) as seen from the window whose newest pixel is (r, c); anything
    // outside the frame or outside the window reads as zero.
    function automatic int tap_value(input int ar, ac, r, c, w, h);
        int i, j;
        i = ar - r + 2;
        j = ac - c + 2;
        if (ar < 0 || ac < 0 || ar >= h || ac >= w || i < 0 || j < 0 || i > 2 || j > 2)
            return 0;
        return int'(taps[i][j]);
    endfunction

    function automatic logic [PIX_W-1:0] filtered_value(input int y, x, r, c, w, h);
        int acc, q, di, dj;
        acc = 0;
        for (di = -1; di <= 1; di++)
            for (dj = -1; dj <= 1; dj++)
                acc += coefficient(1 - di, 1 - dj) * tap_value(y + di, x + dj, r, c, w, h);
        if (acc <= 0)
            return '0;
        q = acc >>> FRAC_W;
        // Round half to even on the eight fraction bits.
        if ((acc & 255) > 128 || ((acc & 255) == 128 && (q & 1) == 1))
            q++;
        return (q > 255) ? 8'd255 : PIX_W'(q);
    endfunction

    task automatic restart_frame();
        int i, j;
        row_at = 0;
        col_at = 0;
        for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
                taps[i][j] = '0;
    endtask

    task automatic apply_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_IMAGE_WIDTH: begin
                frame_width = value[WIDTH_CFG_W-1:0];
                restart_frame();
            end
            CFG_IMAGE_HEIGHT: begin
                frame_height = value[HEIGHT_CFG_W-1:0];
                restart_frame();
            end
            CFG_KERNEL_ROW_TOP: kernel[0] = value[KROW_W-1:0];
            CFG_KERNEL_ROW_MID: kernel[1] = value[KROW_W-1:0];
            CFG_KERNEL_ROW_BOT: kernel[2] = value[KROW_W-1:0];
            default: ;
        endcase
    endtask

    task automatic predict_pixel(input logic [PIX_W-1:0] px);
        int               w, h, r, c, n, k;
        int               ys[4];
        int               xs[4];
        logic [PIX_W-1:0] up, lo;
        filtered_t        res;
        w = (frame_width == 0) ? 1 : (frame_width > MAX_WIDTH ? MAX_WIDTH : int'(frame_width));
        h = (frame_height == 0) ? 1 : int'(frame_height);
        if (col_at >= w)
            col_at = 0;
        if (row_at >= h)
            row_at = 0;
        r = row_at;
        c = col_at;

        up = older_row[c];
        lo = newer_row[c];
        older_row[c] = lo;
        newer_row[c] = px;
        for (k = 0; k < 3; k++) begin
            taps[k][0] = taps[k][1];
            taps[k][1] = taps[k][2];
        end
        taps[0][2] = up;
        taps[1][2] = lo;
        taps[2][2] = px;

        n = 0;
        if (r >= 1 && c >= 1) begin
            ys[n] = r - 1; xs[n] = c - 1; n++;
        end
        if (r >= 1 && c == w - 1) begin
            ys[n] = r - 1; xs[n] = c; n++;
        end
        if (r == h - 1 && c >= 1) begin
            ys[n] = r; xs[n] = c - 1; n++;
        end
        if (r == h - 1 && c == w - 1) begin
            ys[n] = r; xs[n] = c; n++;
        end
        for (k = 0; k < n; k++) begin
            res.pixel = filtered_value(ys[k], xs[k], r, c, w, h);
            res.row   = ROW_W'(ys[k]);
            res.col   = COL_W'(xs[k]);
            res.last  = (k == n - 1);
            res.eof   = (ys[k] == h - 1 && xs[k] == w - 1);
            awaited_pixels.push_back(res);
        end

        col_at++;
        if (col_at >= w) begin
            col_at = 0;
            row_at++;
            if (row_at >= h)
                row_at = 0;
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        filtered_t want;
        int        a;
        if (!i_rst_n) begin
            frame_width  = WIDTH_RESET;
            frame_height = HEIGHT_RESET;
            kernel[0]    = '0;
            kernel[1]    = KERNEL_MID_RESET;
            kernel[2]    = '0;
            for (a = 0; a < MAX_WIDTH; a++) begin
                older_row[a] = '0;
                newer_row[a] = '0;
            end
            awaited_pixels.delete();
            restart_frame();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited_pixels.size() == 0) begin
                    $error("result at row %0d, column %0d arrived with none awaited",
                           i_out_row, i_out_col);
                    mismatches++;
                end else begin
                    want = awaited_pixels.pop_front();
                    check_field("pixel_out", want.pixel, i_pixel_out);
                    check_field("out_row", want.row, i_out_row);
                    check_field("out_col", want.col, i_out_col);
                    check_field("last_of_item", want.last, i_last_of_item);
                    check_field("end_of_frame", want.eof, i_end_of_frame);
                    compared++;
                end
            end
            if (i_cfg_valid && i_cfg_ready)
                apply_write(i_cfg_index, i_cfg_data);
            if (i_in_valid && i_in_ready)
                predict_pixel(i_pixel_in);
        end
        o_mismatches  <= mismatches;
        o_outstanding <= awaited_pixels.size();
        o_compared    <= compared;
    end

endmodule

FILE: sim/tb_conv3x3_zero_pad_saturate_u8.sv
// Stimulus and verdict for the 3x3 convolution block. The checker instantiated
// beside the block watches all three channels, predicts every filtered pixel
// and compares; this module only makes traffic and reports the outcome.
module tb_conv3x3_zero_pad_saturate_u8;
    import c3x3_pkg::*;

    // This limit leaves a wide margin over the slowest plausible run.
    localparam int CYCLE_LIMIT  = 200_000;
    // Pixels that yield no result may still be in flight when the last result
    // has arrived.
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 200;
    localparam int RANDOM_SHARE = 25;

    // Extreme and alternating bit patterns, taken a byte at a time from the bottom.
    localparam logic [95:0] EDGE_PIXELS = 96'h00FF_0180_7FFE_55AA_0FF0_FF00;
    // Three odd values, whose products with a coefficient of one half land exactly on .5, and an even one.
    localparam logic [31:0] TIE_PIXELS  = 32'h02FF_0301;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [PIX_W-1:0]      pixel_in = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [PIX_W-1:0]      pixel_out;
    logic [ROW_W-1:0]      out_row;
    logic [COL_W-1:0]      out_col;
    logic                  last_of_item;
    logic                  end_of_frame;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int pixels_sent = 0;
    int random_pixels = 0;
    int reg_writes = 0;
    int fail_count;
    int outputs_left;
    int outputs_checked;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    conv3x3_zero_pad_saturate_u8 u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_pixel_in     (pixel_in),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_pixel_out    (pixel_out),
        .o_out_row      (out_row),
        .o_out_col      (out_col),
        .o_last_of_item (last_of_item),
        .o_end_of_frame (end_of_frame),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    conv3x3_result_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_pixel_in     (pixel_in),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_pixel_out    (pixel_out),
        .i_out_row      (out_row),
        .i_out_col      (out_col),
        .i_last_of_item (last_of_item),
        .i_end_of_frame (end_of_frame),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_mismatches   (fail_count),
        .o_outstanding  (outputs_left),
        .o_compared     (outputs_checked)
    );

    // Watchdog: a run that hangs is a failed run.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side. Normally ready is drawn at random every cycle; when the
    // stimulus asks for a hold, ready stays low for a long counted stretch so
    // that the block's internal buffering fills and it has to stall its input.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (hold_asked != hold_served) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES - 1;
            out_ready   <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Offers one pixel, possibly after a random gap, and returns at the edge
    // where the transaction completes. Valid is left high so that a following
    // pixel can go back to back; whoever stops sending lowers it.
    task automatic send_pixel(input logic [PIX_W-1:0] px);
        while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= px;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pixels_sent++;
    endtask

    // Stops sending and waits until every predicted result has been delivered,
    // then lets the pipeline drain of pixels that produce nothing. The block is
    // idle afterwards, so register writes are safe.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outputs_left != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register transaction. Valid is left high for a following write; the
    // caller lowers it after the last one.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        reg_writes++;
    endtask

    task automatic configure(input logic [WIDTH_CFG_W-1:0] w, input logic [HEIGHT_CFG_W-1:0] h,
                             input logic [KROW_W-1:0] top, mid, bot);
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(CFG_KERNEL_ROW_TOP, top);
        write_reg(CFG_KERNEL_ROW_MID, mid);
        write_reg(CFG_KERNEL_ROW_BOT, bot);
        cfg_valid <= 1'b0;
    endtask

    // A Q8.8 coefficient: sometimes any 16-bit pattern, mostly values that keep
    // the sums within reach of the 0..255 range so that rounding is exercised.
    function automatic logic [COEF_W-1:0] random_coef();
        case ($urandom_range(0, 3))
            0:       return COEF_W'($urandom);
            1:       return COEF_W'($urandom_range(0, 192) - 96);
            2:       return '0;
            default: return COEF_W'($urandom_range(0, 1024) - 512);
        endcase
    endfunction

    // One frame with a random small geometry and kernel. Most frames are sent
    // whole; some are cut short or run on into the next frame, and some have a
    // kernel row rewritten part way through while the block is idle.
    task automatic random_frame();
        int w_reg, h_reg, total, split, k;
        case ($urandom_range(0, 9))
            0:       w_reg = 0;
            1:       w_reg = $urandom_range(9, 16);
            default: w_reg = $urandom_range(1, 8);
        endcase
        if (w_reg > 8)
            h_reg = $urandom_range(1, 2);
        else
            h_reg = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
        total = ((w_reg == 0) ? 1 : w_reg) * ((h_reg == 0) ? 1 : h_reg);
        case ($urandom_range(0, 7))
            0:       total = $urandom_range(1, total);
            1:       total = total + $urandom_range(1, total);
            default: ;
        endcase
        split = (total > 1 && $urandom_range(0, 3) == 0) ? $urandom_range(1, total - 1) : -1;

        configure(WIDTH_CFG_W'(w_reg), HEIGHT_CFG_W'(h_reg),
                  {random_coef(), random_coef(), random_coef()},
                  {random_coef(), random_coef(), random_coef()},
                  {random_coef(), random_coef(), random_coef()});
        for (k = 0; k < total; k++) begin
            if (k == split) begin
                wait_idle();
                write_reg(CFG_KERNEL_ROW_TOP + CFG_IDX_W'($urandom_range(0, 2)),
                          {random_coef(), random_coef(), random_coef()});
                cfg_valid <= 1'b0;
            end
            send_pixel(PIX_W'($urandom));
        end
        wait_idle();
        random_pixels += total;
    endtask

    initial begin
        int k;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // First idling mode: the sender pauses now and then, the receiver
        // mostly refuses.
        send_idle_pct = 23;
        recv_idle_pct <= 85;

        // The kernel is set to its reset value, the identity, so every output
        // must equal its input; the pixels sweep the extremes and bit patterns.
        configure(11'd4, 12'd3, '0, KERNEL_MID_RESET, '0);
        for (k = 0; k < 12; k++)
            send_pixel(EDGE_PIXELS[8*k +: 8]);
        wait_idle();

        // Zero width and height behave as a single-pixel frame, so each pixel
        // ends a frame. Strong outer coefficients must vanish in the padding.
        // A centre of one half gives exact ties, which must round to even.
        configure('0, '0, 48'h7FFF_8000_7FFF, 48'h0000_0080_0000, 48'h8000_7FFF_8000);
        for (k = 0; k < 4; k++)
            send_pixel(TIE_PIXELS[8*k +: 8]);
        wait_idle();
        // The most negative centre drives the sum of a nonzero pixel below zero.
        write_reg(CFG_KERNEL_ROW_MID, 48'h0000_8000_0000);
        cfg_valid <= 1'b0;
        send_pixel(8'd255);
        send_pixel(8'd0);
        wait_idle();
        // The largest centre saturates a full-scale pixel.
        write_reg(CFG_KERNEL_ROW_MID, 48'h0000_7FFF_0000);
        cfg_valid <= 1'b0;
        send_pixel(8'd255);
        send_pixel(8'd1);
        wait_idle();

        // A 3x2 frame with all nine taps in use, its bottom kernel row replaced
        // between the rows: the second row must use the new coefficients.
        configure(11'd3, 12'd2, 48'hFF80_0100_0040, 48'h0200_FE00_0180, 48'h0060_FFA0_0120);
        for (k = 0; k < 3; k++)
            send_pixel(PIX_W'($urandom));
        wait_idle();
        write_reg(CFG_KERNEL_ROW_BOT, {random_coef(), random_coef(), random_coef()});
        cfg_valid <= 1'b0;
        for (k = 0; k < 3; k++)
            send_pixel(PIX_W'($urandom));
        wait_idle();

        while (random_pixels < RANDOM_SHARE)
            random_frame();

        // Second idling mode: roles swapped.
        send_idle_pct = 85;
        recv_idle_pct <= 23;
        while (random_pixels < 2 * RANDOM_SHARE)
            random_frame();

        // Third mode: neither side idles.
        send_idle_pct = 0;
        recv_idle_pct <= 0;

        // A width beyond the line store acts as the maximum; the start of a
        // single-row frame of that width is sent before the next geometry
        // write restarts it.
        configure(11'd2047, 12'd1, {random_coef(), random_coef(), random_coef()},
                  {random_coef(), random_coef(), random_coef()},
                  {random_coef(), random_coef(), random_coef()});
        for (k = 0; k < 24; k++)
            send_pixel(PIX_W'($urandom));
        wait_idle();

        // The tallest frame, one column wide; only its start is sent before
        // the next geometry write restarts it.
        configure(11'd1, 12'd4095, {random_coef(), random_coef(), random_coef()},
                  {random_coef(), random_coef(), random_coef()},
                  {random_coef(), random_coef(), random_coef()});
        for (k = 0; k < 40; k++)
            send_pixel(PIX_W'($urandom));
        wait_idle();

        // Back-pressure: the receiver holds off for a long stretch while a whole
        // frame is offered, so the block has to stall its input.
        configure(11'd8, 12'd6, {random_coef(), random_coef(), random_coef()},
                  {random_coef(), random_coef(), random_coef()},
                  {random_coef(), random_coef(), random_coef()});
        hold_asked <= hold_asked + 1;
        for (k = 0; k < 48; k++)
            send_pixel(PIX_W'($urandom));
        wait_idle();

        while (random_pixels < 3 * RANDOM_SHARE)
            random_frame();

        $display("Sent %0d pixels with %0d register writes; %0d filtered pixels compared.",
                 pixels_sent, reg_writes, outputs_checked);
        $display("Covered rounding ties, saturation, degenerate and oversized geometry, %s",
                 "mid-frame kernel changes and a long output hold.");
        if (fail_count == 0 && outputs_left == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/c3x3_pkg.sv
rtl/core/c3x3_line_buf.sv
rtl/core/c3x3_seq.sv
rtl/core/c3x3_mac.sv
rtl/core/conv3x3_zero_pad_saturate_u8.sv
rtl/core/c3x3_checker.sv
sim/conv3x3_result_checker.sv
sim/tb_conv3x3_zero_pad_saturate_u8.sv
